/* rtl/srl_pkg.sv */
package srl_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharS = 8'h53;
  localparam logic [7:0] CaseMask = 8'hdf;
  localparam logic [7:0] LetterBase = 8'd55;
  localparam logic [7:0] DigitFix = 8'd39;
  localparam logic [9:0] ColumnMax = 10'd1023;

  typedef enum logic {
    EV_WRITE = 1'b0,
    EV_JUMP  = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic       is_s;
    logic [3:0] nib;
  } token_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    logic [7:0] r;
    begin
      v = c & CaseMask;
      if (v < LetterBase) begin
        r = v + DigitFix - LetterBase;
      end else begin
        r = v - LetterBase;
      end
      return r[3:0];
    end
  endfunction

  function automatic logic [3:0] addr_digits(input logic [3:0] t);
    logic [4:0] n;
    begin
      if (t <= 4'd3) begin
        n = ({1'b0, t} + 5'd1) << 1;
      end else if (t <= 4'd10) begin
        n = (5'd11 - {1'b0, t}) << 1;
      end else begin
        n = 5'd0;
      end
      return n[3:0];
    end
  endfunction

endpackage

/* rtl/srl_front.sv */
module srl_front (
  input  logic             char_valid,
  input  logic [7:0]       char_in,
  input  srl_pkg::queue_status_t q_status,
  output logic             char_stall,
  output logic             push,
  output srl_pkg::token_t  push_token
);

  // classify the character: start mark or hex digit
  always_comb begin
    char_stall = q_status.full;
    push = char_valid && !q_status.full;
    push_token.is_s = (char_in == srl_pkg::CharS);
    push_token.nib = srl_pkg::hex_nibble(char_in);
  end

endmodule

/* rtl/srl_queue.sv */
module srl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  srl_pkg::token_t  push_token,
  input  logic             pop,
  output srl_pkg::token_t  pop_token,
  output srl_pkg::queue_status_t q_status
);

  srl_pkg::token_t entries [srl_pkg::QueueDepth];
  logic [srl_pkg::PtrWidth-1:0] wr_ptr;
  logic [srl_pkg::PtrWidth-1:0] rd_ptr;
  logic [srl_pkg::CountWidth-1:0] count;

  localparam logic [srl_pkg::PtrWidth-1:0] LastPtr =
    srl_pkg::PtrWidth'(srl_pkg::QueueDepth - 1);
  localparam logic [srl_pkg::CountWidth-1:0] FullCount =
    srl_pkg::CountWidth'(srl_pkg::QueueDepth);

  always_comb begin
    q_status.empty = (count == '0);
    q_status.full = (count == FullCount);
    pop_token = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/srl_back.sv */
module srl_back (
  input  logic             clk,
  input  logic             rst,
  input  srl_pkg::queue_status_t q_status,
  input  srl_pkg::token_t  pop_token,
  output logic             pop,
  input  logic             event_stall,
  output logic             event_valid,
  output logic             event_kind,
  output logic [31:0]      target_address,
  output logic [7:0]       byte_value
);

  logic [9:0]  column;
  logic [31:0] address_acc;
  logic [3:0]  address_digits;
  logic [7:0]  byte_count;
  logic [3:0]  record_type;
  logic        nibble_phase;
  logic [7:0]  data_acc;
  logic        halted;

  logic [9:0]  column_next;
  logic [31:0] address_acc_next;
  logic [3:0]  address_digits_next;
  logic [7:0]  byte_count_next;
  logic [3:0]  record_type_next;
  logic        nibble_phase_next;
  logic [7:0]  data_acc_next;
  logic        halted_next;

  logic        emit;
  srl_pkg::event_kind_t emit_kind;
  logic [31:0] emit_addr;
  logic [7:0]  emit_byte;
  logic [9:0]  col_inc;
  logic [7:0]  data_shift;
  logic        is_data_type;
  logic        is_jump_type;

  always_comb begin
    pop = !q_status.empty && (!event_valid || !event_stall);
    col_inc = (column < srl_pkg::ColumnMax) ? column + 10'd1 : column;
    data_shift = {data_acc[3:0], pop_token.nib};
    is_data_type = (record_type >= 4'd1) && (record_type <= 4'd3);
    is_jump_type = (record_type >= 4'd7) && (record_type <= 4'd9);

    column_next = column;
    address_acc_next = address_acc;
    address_digits_next = address_digits;
    byte_count_next = byte_count;
    record_type_next = record_type;
    nibble_phase_next = nibble_phase;
    data_acc_next = data_acc;
    halted_next = halted;
    emit = 1'b0;
    emit_kind = srl_pkg::EV_WRITE;
    emit_addr = address_acc;
    emit_byte = '0;

    if (pop && !halted) begin
      column_next = col_inc;
      if (pop_token.is_s) begin
        column_next = '0;
        address_acc_next = '0;
        byte_count_next = '0;
        record_type_next = '0;
      end else if (col_inc == 10'd1) begin
        record_type_next = pop_token.nib;
        address_digits_next = srl_pkg::addr_digits(pop_token.nib);
      end else if (col_inc <= 10'd3) begin
        byte_count_next = {byte_count[3:0], pop_token.nib};
      end else if (col_inc <= {6'd0, address_digits} + 10'd3) begin
        address_acc_next = {address_acc[27:0], pop_token.nib};
        nibble_phase_next = 1'b1;
      end else if (is_data_type) begin
        if (col_inc <= {1'b0, byte_count, 1'b0} + 10'd1) begin
          data_acc_next = data_shift;
          if (nibble_phase) begin
            nibble_phase_next = 1'b0;
          end else begin
            emit = 1'b1;
            emit_byte = data_shift;
            address_acc_next = address_acc + 32'd1;
            nibble_phase_next = 1'b1;
          end
        end else if (!nibble_phase) begin
          // lone trailing nibble
          data_acc_next = {data_acc[3:0], 4'd0};
          emit = 1'b1;
          emit_byte = {data_acc[3:0], 4'd0};
        end
      end else if (is_jump_type) begin
        emit = 1'b1;
        emit_kind = srl_pkg::EV_JUMP;
        halted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      address_acc <= '0;
      address_digits <= '0;
      byte_count <= '0;
      record_type <= '0;
      nibble_phase <= 1'b0;
      data_acc <= '0;
      halted <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      column <= column_next;
      address_acc <= address_acc_next;
      address_digits <= address_digits_next;
      byte_count <= byte_count_next;
      record_type <= record_type_next;
      nibble_phase <= nibble_phase_next;
      data_acc <= data_acc_next;
      halted <= halted_next;
      if (emit) begin
        event_valid <= 1'b1;
      end else if (!event_stall) begin
        event_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind <= emit_kind;
      target_address <= emit_addr;
      byte_value <= emit_byte;
    end
  end

endmodule

/* rtl/srecord_loader.sv */
// S-record loader: takes one ASCII character per request on the char channel
// and sends byte-write and jump requests on the event channel. One character
// is accepted every clock cycle while char_stall is low; a character's event
// passes through a two-entry token queue and then the parser's output
// register. char_stall rises only when that queue is full, which happens as
// soon as one or two characters arrive while a pending event request is
// stalled. After a jump request the loader ignores all input until reset.
module srecord_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_in,
  output logic        event_valid,
  input  logic        event_stall,
  output logic        event_kind,
  output logic [31:0] target_address,
  output logic [7:0]  byte_value
);

  srl_pkg::queue_status_t q_status;
  srl_pkg::token_t push_token;
  srl_pkg::token_t pop_token;
  logic push;
  logic pop;

  srl_front u_front (
    .char_valid (char_valid),
    .char_in    (char_in),
    .q_status   (q_status),
    .char_stall (char_stall),
    .push       (push),
    .push_token (push_token)
  );

  srl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .pop_token  (pop_token),
    .q_status   (q_status)
  );

  srl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .pop_token      (pop_token),
    .pop            (pop),
    .event_stall    (event_stall),
    .event_valid    (event_valid),
    .event_kind     (event_kind),
    .target_address (target_address),
    .byte_value     (byte_value)
  );

endmodule

/* rtl/srl_checker.sv */
module srl_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_stall,
  input logic        event_valid,
  input logic        event_stall,
  input logic        event_kind,
  input logic [31:0] target_address,
  input logic [7:0]  byte_value
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(event_kind)
      && $stable(target_address) && $stable(byte_value))
    else $error("stalled event request changed");

  a_jump_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind |-> byte_value == 8'd0)
    else $error("jump request with nonzero byte");

  a_halt: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_stall && event_kind |=> !event_valid)
    else $error("event request after jump");

  a_reset: assert property (@(posedge clk)
    rst |=> !event_valid && !char_stall)
    else $error("request pending right after reset");

endmodule

bind srecord_loader srl_checker u_srl_checker (
  .clk            (clk),
  .rst            (rst),
  .char_stall     (char_stall),
  .event_valid    (event_valid),
  .event_stall    (event_stall),
  .event_kind     (event_kind),
  .target_address (target_address),
  .byte_value     (byte_value)
);
